// ===== rtl/h2b64_pkg.sv =====
// Shared types, codes and character functions for the hex to Base64 stream unit.
`default_nettype none

package h2b64_pkg;

   localparam int unsigned QueueDepth = 4;

   // Kind of work handed from the front end to the back end
   localparam logic [1:0] JOB_FULL = 2'd0;
   localparam logic [1:0] JOB_ONE  = 2'd1;
   localparam logic [1:0] JOB_TWO  = 2'd2;
   localparam logic [1:0] JOB_ERR  = 2'd3;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] LOWER_A    = 8'h61;

   typedef struct packed {
      logic [1:0]  kind;
      logic        last;
      logic [23:0] group;
   } job_type;

   // Full 8-bit digit value; the high digit of a pair keeps only its low four bits,
   // the low digit is added whole, so characters outside the hex set can carry.
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      if (c >= DIGIT_ZERO && c <= 8'h39) begin
         d = c - DIGIT_ZERO;
      end else if (c >= UPPER_A && c <= 8'h5A) begin
         d = c - UPPER_A + 8'd10;
      end else begin
         d = c - LOWER_A + 8'd10;
      end
      return d;
   endfunction

   function automatic logic [7:0] b64_symbol(input logic [5:0] s);
      logic [7:0] s8;
      logic [7:0] r;
      s8 = {2'b00, s};
      if (s < 6'd26) begin
         r = UPPER_A + s8;
      end else if (s < 6'd52) begin
         r = LOWER_A + s8 - 8'd26;
      end else if (s < 6'd62) begin
         r = DIGIT_ZERO + s8 - 8'd52;
      end else if (s == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/h2b64_if.sv =====
// Valid/ready channel interfaces for hex input words and Base64 result words.
`default_nettype none

interface h2b64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] hex_char;
   logic       last_char;

   modport source (output valid, output hex_char, output last_char, input ready);
   modport sink   (input valid, input hex_char, input last_char, output ready);
endinterface

interface h2b64_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] b64_char;
   logic       last_out;
   logic       odd_length_error;

   modport source (output valid, output b64_char, output last_out,
                   output odd_length_error, input ready);
   modport sink   (input valid, input b64_char, input last_out,
                   input odd_length_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/h2b64_front.sv =====
// Front end: pairs hex digits into bytes, gathers groups and issues encode jobs.
`default_nettype none

module h2b64_front
   import h2b64_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   h2b64_req_if.sink    req_chan,
   input  wire logic    q_ready,
   output logic         push,
   output job_type      push_job
);

   logic        nib_wait_ff, nib_wait_in;
   logic [3:0]  nib_ff, nib_in;
   logic [15:0] grp_ff, grp_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic        accept;
   logic [7:0]  digit;
   logic [7:0]  byte_val;

   assign req_chan.ready = q_ready;
   assign accept   = req_chan.valid && q_ready;
   assign digit    = digit_value(req_chan.hex_char);
   assign byte_val = {nib_ff, 4'h0} + digit;

   always_comb begin
      nib_wait_in    = nib_wait_ff;
      nib_in         = nib_ff;
      grp_in         = grp_ff;
      cnt_in         = cnt_ff;
      push           = 1'b0;
      push_job.kind  = JOB_ERR;
      push_job.last  = 1'b1;
      push_job.group = 24'h0;
      if (accept) begin
         if (!nib_wait_ff) begin
            if (req_chan.last_char) begin
               // string ended on half a byte: report and drop the partial group
               push   = 1'b1;
               cnt_in = 2'd0;
               grp_in = 16'h0;
            end else begin
               nib_in      = digit[3:0];
               nib_wait_in = 1'b1;
            end
         end else begin
            nib_wait_in = 1'b0;
            if (cnt_ff == 2'd2) begin
               push           = 1'b1;
               push_job.kind  = JOB_FULL;
               push_job.last  = req_chan.last_char;
               push_job.group = {grp_ff, byte_val};
               cnt_in         = 2'd0;
               grp_in         = 16'h0;
            end else if (req_chan.last_char) begin
               push = 1'b1;
               if (cnt_ff == 2'd0) begin
                  push_job.kind  = JOB_ONE;
                  push_job.group = {byte_val, 16'h0};
               end else begin
                  push_job.kind  = JOB_TWO;
                  push_job.group = {grp_ff[15:8], byte_val, 8'h0};
               end
               cnt_in = 2'd0;
               grp_in = 16'h0;
            end else begin
               if (cnt_ff == 2'd0) begin
                  grp_in[15:8] = byte_val;
               end else begin
                  grp_in[7:0] = byte_val;
               end
               cnt_in = cnt_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nib_wait_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         grp_ff      <= 16'h0;
      end else begin
         nib_wait_ff <= nib_wait_in;
         cnt_ff      <= cnt_in;
         grp_ff      <= grp_in;
      end
      nib_ff <= nib_in;
   end

endmodule

`default_nettype wire

// ===== rtl/h2b64_queue.sv =====
// Short register queue of encode jobs between front and back ends.
`default_nettype none

module h2b64_queue
   import h2b64_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         not_full,
   output logic         not_empty,
   output job_type      head
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);
   localparam logic [PtrW-1:0] LastSlot  = PtrW'(DEPTH - 1);

   job_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign not_full  = (count_ff != FullCount);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/h2b64_back.sv =====
// Back end: registers each job's Base64 characters, one per cycle unless output stalls.
`default_nettype none

module h2b64_back
   import h2b64_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire job_type q_head,
   output logic         q_pop,
   h2b64_rsp_if.source  rsp_chan
);

   logic       job_valid_ff, job_valid_in;
   job_type    job_ff, job_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;
   logic       out_err_ff, out_err_in;

   logic       out_load;
   logic       final_char;
   logic       pad;
   logic [5:0] sextet;

   assign out_load   = job_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign final_char = (job_ff.kind == JOB_ERR) || (idx_ff == 2'd3);
   assign q_pop      = q_valid && (!job_valid_ff || (out_load && final_char));

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = job_ff.group[23:18];
         2'd1:    sextet = job_ff.group[17:12];
         2'd2:    sextet = job_ff.group[11:6];
         default: sextet = job_ff.group[5:0];
      endcase
   end

   always_comb begin
      case (job_ff.kind)
         JOB_ONE: pad = idx_ff[1];
         JOB_TWO: pad = (idx_ff == 2'd3);
         default: pad = 1'b0;
      endcase
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      if (out_load) begin
         idx_in = idx_ff + 2'd1;
         if (final_char) begin
            job_valid_in = 1'b0;
         end
      end
      // take the next job when idle or as the current one hands out its final character
      if (q_pop) begin
         job_valid_in = 1'b1;
         job_in       = q_head;
         idx_in       = 2'd0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         if (job_ff.kind == JOB_ERR) begin
            out_char_in = 8'h00;
            out_last_in = 1'b1;
            out_err_in  = 1'b1;
         end else begin
            out_char_in = pad ? PAD_CHAR : b64_symbol(sextet);
            out_last_in = job_ff.last && (idx_ff == 2'd3);
            out_err_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.b64_char         = out_char_ff;
   assign rsp_chan.last_out         = out_last_ff;
   assign rsp_chan.odd_length_error = out_err_ff;

endmodule

`default_nettype wire

// ===== rtl/hex_to_base64_stream_unit.sv =====
// Hex character stream to Base64 character stream encoder, top level.
//
// One hex character word is taken per cycle while the job queue has room. Every
// six characters (three bytes) produce four Base64 words; at the last character
// a partial group is flushed with '=' padding, and a string that ends on half a
// byte gives a single word with odd_length_error and last_out set. The back end
// hands out one result word per cycle while the output is not stalled, so over
// long strings input runs at one word per cycle; a string ending in a short
// group yields four output words for its final two or four characters, absorbed
// by a QUEUE_DEPTH-entry job queue before the input stalls. With the back end
// idle, a job goes through the queue slot, the job register and the output
// register; behind earlier jobs or a stalled output it waits longer. Input and
// output stall independently through the queue and the registered output.
`default_nettype none

module hex_to_base64_stream_unit
   import h2b64_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  wire logic    clock,
   input  wire logic    reset,
   h2b64_req_if.sink    req_chan,
   h2b64_rsp_if.source  rsp_chan
);

   logic    push;
   job_type push_job;
   logic    q_not_full;
   logic    q_not_empty;
   logic    q_pop;
   job_type q_head;

   h2b64_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_ready  (q_not_full),
      .push     (push),
      .push_job (push_job)
   );

   h2b64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (q_pop),
      .not_full  (q_not_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   h2b64_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_not_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/h2b64_checker.sv =====
// Port-level assertions for the hex to Base64 stream unit, bound to the top level.
`default_nettype none

module h2b64_checker
   import h2b64_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_b64_char,
   input wire logic       rsp_last_out,
   input wire logic       rsp_odd_length_error
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_b64_char)
         && $stable(rsp_last_out) && $stable(rsp_odd_length_error))
      else $error("stalled result word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_odd_length_error |-> rsp_last_out && (rsp_b64_char == 8'h00))
      else $error("error word must be final and carry a zero character");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_odd_length_error |-> rsp_b64_char != 8'h00)
      else $error("encoded word carries a zero character");

   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result word present straight after reset");

endmodule

bind hex_to_base64_stream_unit h2b64_checker u_h2b64_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_b64_char         (rsp_chan.b64_char),
   .rsp_last_out         (rsp_chan.last_out),
   .rsp_odd_length_error (rsp_chan.odd_length_error)
);

`default_nettype wire

// ===== dv/h2b64_stream_checker.sv =====
// Predicts the Base64 words due for each accepted hex word and checks the result channel.
`timescale 1ns / 100ps

module h2b64_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_hex_char,
   input  logic       req_last_char,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_b64_char,
   input  logic       rsp_last_out,
   input  logic       rsp_odd_length_error,
   output int         words_outstanding,
   output int         words_checked,
   output int         fail_count
);

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
      logic       odd_error;
   } b64_word_type;

   localparam logic [7:0] PadSymbol = 8'h3D;

   b64_word_type b64_words_due[$];
   b64_word_type seen_word;
   b64_word_type due_word;

   // encoder state
   logic [7:0]  high_digit;
   logic        half_byte_held;
   logic [23:0] group_bits;
   int          group_bytes;

   int          checked;
   int          mismatches;

   function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return c - "0";
      end else if (c >= "A" && c <= "Z") begin
         return c - "A" + 8'd10;
      end
      return c - "a" + 8'd10;
   endfunction

   // i-th sextet of a group, most significant first, as an alphabet symbol
   function automatic logic [7:0] group_symbol(input logic [23:0] g, input int i);
      string       alphabet;
      logic [23:0] shifted;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      shifted  = g >> (18 - 6 * i);
      return alphabet[shifted[5:0]];
   endfunction

   function automatic void add_due(input logic [7:0] symbol, input logic last,
                                   input logic odd_error);
      b64_word_type w;
      w.symbol    = symbol;
      w.last      = last;
      w.odd_error = odd_error;
      b64_words_due.push_back(w);
   endfunction

   function automatic void clear_encoder();
      high_digit     = '0;
      half_byte_held = 1'b0;
      group_bits     = '0;
      group_bytes    = 0;
   endfunction

   function automatic void encode_hex_word(input logic [7:0] c, input logic is_last);
      logic [7:0] octet;
      int         n;
      if (!half_byte_held) begin
         if (is_last) begin
            // string ends on half a byte
            add_due(8'h00, 1'b1, 1'b1);
            clear_encoder();
         end else begin
            high_digit     = hex_digit_value(c);
            half_byte_held = 1'b1;
         end
         return;
      end
      octet          = (high_digit << 4) + hex_digit_value(c);
      half_byte_held = 1'b0;
      high_digit     = '0;
      n              = group_bytes;
      group_bits     = group_bits | ({16'h0000, octet} << (16 - 8 * n));
      n++;
      if (n == 3) begin
         for (int i = 0; i < 4; i++) begin
            add_due(group_symbol(group_bits, i), is_last && i == 3, 1'b0);
         end
         clear_encoder();
      end else if (!is_last) begin
         group_bytes = n;
      end else begin
         // flush a short group, pad to four symbols
         for (int i = 0; i < 4; i++) begin
            add_due((i < n + 1) ? group_symbol(group_bits, i) : PadSymbol, i == 3, 1'b0);
         end
         clear_encoder();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         b64_words_due.delete();
         clear_encoder();
         checked    = 0;
         mismatches = 0;
      end else begin
         if (req_valid && req_ready) begin
            encode_hex_word(req_hex_char, req_last_char);
         end
         if (rsp_valid && rsp_ready) begin
            seen_word.symbol    = rsp_b64_char;
            seen_word.last      = rsp_last_out;
            seen_word.odd_error = rsp_odd_length_error;
            if (b64_words_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word: expected none, got char %h last %b error %b",
                        $time, rsp_b64_char, rsp_last_out, rsp_odd_length_error);
            end else begin
               due_word = b64_words_due.pop_front();
               checked++;
               if (seen_word !== due_word) begin
                  mismatches++;
                  if (seen_word.symbol !== due_word.symbol) begin
                     $display("%0t: b64_char expected %h got %h",
                              $time, due_word.symbol, seen_word.symbol);
                  end
                  if (seen_word.last !== due_word.last) begin
                     $display("%0t: last_out expected %b got %b",
                              $time, due_word.last, seen_word.last);
                  end
                  if (seen_word.odd_error !== due_word.odd_error) begin
                     $display("%0t: odd_length_error expected %b got %b",
                              $time, due_word.odd_error, seen_word.odd_error);
                  end
               end
            end
         end
      end
      words_outstanding <= b64_words_due.size();
      words_checked     <= checked;
      fail_count        <= mismatches;
   end

endmodule

// ===== dv/hex_to_base64_stream_unit_test.sv =====
// Top of the hex to Base64 stream unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module hex_to_base64_stream_unit_test;

   localparam int CycleLimit    = 200000;
   localparam int RandomItems   = 180;
   localparam int DrainCycles   = 20;
   localparam int SqueezeCycles = 80;

   logic clock;
   logic reset;

   h2b64_req_if req_chan ();
   h2b64_rsp_if rsp_chan ();

   int words_outstanding;
   int words_checked;
   int fail_count;
   int words_sent;
   int strings_sent;
   int odd_strings;
   int chars_in_string;
   int cycle_count;
   bit flat_out;
   bit squeeze_req;
   bit squeeze_done;

   hex_to_base64_stream_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   h2b64_stream_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_chan.valid),
      .req_ready            (req_chan.ready),
      .req_hex_char         (req_chan.hex_char),
      .req_last_char        (req_chan.last_char),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_b64_char         (rsp_chan.b64_char),
      .rsp_last_out         (rsp_chan.last_out),
      .rsp_odd_length_error (rsp_chan.odd_length_error),
      .words_outstanding    (words_outstanding),
      .words_checked        (words_checked),
      .fail_count           (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 25);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic is_last);
      int gap;
      gap = (flat_out || (squeeze_req && !squeeze_done)) ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.hex_char  <= c;
      req_chan.last_char <= is_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
      chars_in_string++;
      if (is_last) begin
         strings_sent++;
         if (chars_in_string % 2 == 1) begin
            odd_strings++;
         end
         chars_in_string = 0;
      end
   endtask

   task automatic send_string(input string s);
      for (int k = 0; k < s.len(); k++) begin
         send_char(s[k], k == s.len() - 1);
      end
   endtask

   task automatic send_random_string();
      string      digits;
      int         r;
      int         len;
      logic [7:0] c;
      digits = "0123456789abcdefABCDEF";
      r      = $urandom_range(0, 99);
      if (r < 15) begin
         len = 2 * $urandom_range(0, 6) + 1;
      end else if (r < 25) begin
         len = 2 * $urandom_range(7, 20);
      end else begin
         len = 2 * $urandom_range(1, 6);
      end
      flat_out = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 4) == 0) begin
            c = 8'($urandom_range(0, 255));
         end else begin
            c = digits[$urandom_range(0, 21)];
         end
         send_char(c, k == len - 1);
      end
   endtask

   // hold input until every predicted word has come out
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);
   endtask

   // result side: random ready runs and gaps, one long hold-off on request
   initial begin
      int run;
      int gap;
      rsp_chan.ready <= 1'b0;
      squeeze_done = 1'b0;
      @(posedge clock);
      forever begin
         if (squeeze_req && !squeeze_done) begin
            rsp_chan.ready <= 1'b0;
            for (int k = 0; k < SqueezeCycles; k++) begin
               @(posedge clock);
            end
            squeeze_done = 1'b1;
         end else begin
            run = $urandom_range(1, 40);
            rsp_chan.ready <= 1'b1;
            repeat (run) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: timeout after %0d cycles, %0d words still due", cycle_count,
               words_outstanding);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int random_base;
      bit paused;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.hex_char  <= 8'h00;
      req_chan.last_char <= 1'b0;
      flat_out        = 1'b0;
      squeeze_req     = 1'b0;
      words_sent      = 0;
      strings_sent    = 0;
      odd_strings     = 0;
      chars_in_string = 0;
      paused          = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full group on last, two and one leftover bytes, odd lengths
      send_string("4d616e");
      send_string("4d61");
      send_string("4d");
      send_string("F");
      send_string("abcdef1");
      // byte extremes and characters outside the hex set
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char("z", 1'b0);
      send_char(8'h80, 1'b1);
      wait_drained();

      // hold off the result side while input runs flat out
      squeeze_req = 1'b1;
      random_base = words_sent;
      while (words_sent - random_base < RandomItems) begin
         send_random_string();
         if (!paused && words_sent - random_base >= RandomItems / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
      wait_drained();
      repeat (DrainCycles) @(posedge clock);

      $display("tb: drove %0d hex words in %0d strings, %0d of them odd length",
               words_sent, strings_sent, odd_strings);
      $display("tb: compared %0d Base64 words, with one %0d-cycle output hold-off",
               words_checked, SqueezeCycles);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
